@@ src/wde_pkg.sv @@
// Shared constants, codes and handshake structs for the windowed derivative estimator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package wde_pkg;

  // Ring and field sizes.
  localparam int MAX_WINDOW = 32;
  localparam int RING_DEPTH = MAX_WINDOW + 1;
  localparam int SLOT_W     = $clog2(RING_DEPTH);
  localparam int SAMPLE_W   = 16;
  localparam int STEP_W     = 16;
  localparam int ENTRY_W    = SAMPLE_W + STEP_W;
  localparam int FRAC_W     = 16;
  localparam int VALUE_W    = 32;
  localparam int NUM_W      = SAMPLE_W + FRAC_W;
  localparam int SUM_W      = $clog2((MAX_WINDOW + 1) * (1 << STEP_W));
  localparam int DIFF_W     = SAMPLE_W + 1;

  // Configuration registers.
  localparam int WIN_W      = 6;
  localparam int GAIN_W     = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;
  localparam int CMP_W      = (WIN_W > SLOT_W) ? WIN_W : SLOT_W;
  localparam int PROD_W     = VALUE_W + GAIN_W + 1;

  localparam logic [WIN_W-1:0]   WIN_RESET  = WIN_W'(4);
  localparam logic [GAIN_W-1:0]  GAIN_RESET = GAIN_W'(32768);
  localparam logic [GAIN_W-1:0]  GAIN_ONE   = GAIN_W'(65536);

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = CFG_IDX_W'(1);

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  // Divider request and response.
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [SUM_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

@@ src/wde_if.sv @@
// Request and result channel interfaces of the windowed derivative estimator.
// Depends on wde_pkg for the field widths.
`default_nettype none

interface wde_in_if;
  import wde_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic signed [SAMPLE_W-1:0] sample;
  logic [STEP_W-1:0]          time_step;

  modport source (output valid, output req_type, output sample, output time_step,
                  input ready);
  modport sink   (input valid, input req_type, input sample, input time_step,
                  output ready);
endinterface

interface wde_out_if;
  import wde_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      is_ready;

  modport source (output valid, output value, output is_ready, input ready);
  modport sink   (input valid, input value, input is_ready, output ready);
endinterface

`default_nettype wire

@@ src/wde_ring_mem.sv @@
// Synchronous ring memory holding sample and time step per slot, one write and one read port.
// Depends on wde_pkg for depth and widths.
`default_nettype none

module wde_ring_mem (
  input  wire logic                          clk_i,
  input  wire logic                          we_i,
  input  wire logic [wde_pkg::SLOT_W-1:0]    waddr_i,
  input  wire logic [wde_pkg::ENTRY_W-1:0]   wdata_i,
  input  wire logic [wde_pkg::SLOT_W-1:0]    raddr_i,
  output logic      [wde_pkg::ENTRY_W-1:0]   rdata_o
);
  import wde_pkg::*;

  logic [ENTRY_W-1:0] mem [RING_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

@@ src/wde_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on wde_pkg for the request and response structs.
`default_nettype none

module wde_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire wde_pkg::div_req_t req_i,
  output wde_pkg::div_rsp_t      rsp_o
);
  import wde_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [SUM_W:0]   rem_q, rem_sh;
  logic [NUM_W-1:0] quo_q;
  logic [SUM_W-1:0] den_q;
  logic             fits;

  // Bring down the next numerator bit and try the subtraction.
  assign rem_sh = {rem_q[SUM_W-1:0], quo_q[NUM_W-1]};
  assign fits   = (rem_sh >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.num;
      den_q <= req_i.den;
    end else if (busy_q) begin
      rem_q <= fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
      quo_q <= {quo_q[NUM_W-2:0], fits};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

`default_nettype wire

@@ src/windowed_derivative_estimator.sv @@
// Top level of the windowed derivative estimator: control sequencer, ring memory and filter.
// Depends on wde_pkg, wde_if, wde_ring_mem and wde_div.
`default_nettype none

// The block takes one request at a time. A sample request goes into a ring of window_length+1
// slots kept in a single synchronous memory: the sample and its time step are written at the
// current slot in the cycle the request is taken, and the slot one window back is read in the
// same cycle. A running sum of the last window_length time steps is updated from that read,
// and the difference of samples, scaled to Q16.16, is divided by the sum in a restoring divider
// that produces one quotient bit per cycle over 32 steps. The quotient is saturated to 32 bits
// and fed to an exponential filter built from two registered multiplies. Once filtering is
// live, a sample request passes through the read, divide, saturate, two multiply and final
// states before the result stage; before the first wrap the filter states are skipped. The
// next request is taken only after the result is loaded. Clear requests and requests with a
// window of one skip the divider and go straight to the result stage. The result sits in an
// output register, so a new request is taken while an earlier result waits to be delivered.
// A window of one returns the sample with is_ready high; otherwise results read 0 with
// is_ready low until the ring first wraps; at that wrap the filter is seeded with the raw
// derivative, and from the next sample on the filtered value is delivered with is_ready high.
// The memory needs no clearing pass after reset or a clear: a slot read before the ring has
// wrapped is known to be unwritten and is taken as zero. Writing window_length clears the
// ring, sum, filter and ready flag just as a clear request does; writes to registers are
// expected only while the block is idle.
module windowed_derivative_estimator (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  wde_in_if.sink                               in_if,
  wde_out_if.source                            out_if,
  input  wire logic                            cfg_we_i,
  input  wire logic [wde_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [wde_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import wde_pkg::*;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_SAT  = 3'd3;
  localparam logic [2:0] S_MUL1 = 3'd4;
  localparam logic [2:0] S_MUL2 = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state_q, state_d;

  // Configuration.
  logic [WIN_W-1:0]  win_q;
  logic [GAIN_W-1:0] gain_q;
  logic [CMP_W-1:0]  win_c;
  logic [SLOT_W-1:0] len;
  logic [GAIN_W-1:0] g_eff;
  logic              cfg_clear;

  // Block state.
  logic [SLOT_W-1:0]          slot_q;
  logic [SUM_W-1:0]           sum_q;
  logic signed [VALUE_W-1:0]  filt_q;
  logic                       ready_q;

  // Per-request working registers.
  logic signed [SAMPLE_W-1:0] s_q;
  logic [STEP_W-1:0]          dt_q;
  logic                       rd_is0_q;
  logic                       neg_q;
  logic signed [VALUE_W-1:0]  d_q;
  logic signed [PROD_W-1:0]   p1_q;
  logic signed [PROD_W-1:0]   acc_q;
  logic signed [VALUE_W-1:0]  res_q;
  logic                       live_q;

  // Output register.
  logic                       out_valid_q;
  logic signed [VALUE_W-1:0]  out_value_q;
  logic                       out_live_q;

  // Memory ports.
  logic                       mem_we;
  logic [SLOT_W-1:0]          rd_slot;
  logic [ENTRY_W-1:0]         mem_rdata;

  logic                       accept;
  logic                       out_free;
  logic                       old_valid;
  logic signed [SAMPLE_W-1:0] old_s;
  logic [STEP_W-1:0]          old_dt;
  logic [SUM_W-1:0]           sum_d;
  logic signed [DIFF_W-1:0]   diff;
  logic [DIFF_W-1:0]          mag;
  logic signed [VALUE_W-1:0]  d_sat;
  logic signed [PROD_W-1:0]   acc_adj;
  logic signed [VALUE_W-1:0]  filt_new;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // Effective window, clamped to 1..MAX_WINDOW, and gain, clamped to one.
  always_comb begin
    win_c = CMP_W'(win_q);
    if (win_c == '0) begin
      len = SLOT_W'(1);
    end else if (win_c > CMP_W'(MAX_WINDOW)) begin
      len = SLOT_W'(MAX_WINDOW);
    end else begin
      len = SLOT_W'(win_c);
    end
    g_eff = (gain_q > GAIN_ONE) ? GAIN_ONE : gain_q;
  end

  assign accept   = in_if.valid && in_if.ready;
  assign out_free = !out_valid_q || out_if.ready;

  // The slot one window back is the slot after the one being written, wrapping at len.
  assign rd_slot  = (slot_q == len) ? '0 : slot_q + 1'b1;
  assign mem_we   = accept && (in_if.req_type == REQ_SAMPLE) && (len != SLOT_W'(1));

  wde_ring_mem u_ring (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (slot_q),
    .wdata_i ({in_if.sample, in_if.time_step}),
    .raddr_i (rd_slot),
    .rdata_o (mem_rdata)
  );

  // Before the first wrap only slot zero has been written among the slots we read back, and
  // only at the wrap itself; every other read is of a slot not yet written and is taken as zero.
  assign old_valid = ready_q || rd_is0_q;
  assign old_s     = old_valid ? $signed(mem_rdata[ENTRY_W-1:STEP_W]) : '0;
  assign old_dt    = old_valid ? mem_rdata[STEP_W-1:0] : '0;
  assign sum_d     = sum_q + SUM_W'(dt_q) - SUM_W'(old_dt);
  assign diff      = DIFF_W'(s_q) - DIFF_W'(old_s);
  assign mag       = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

  assign div_req.start = (state_q == S_READ);
  assign div_req.num   = {mag[SAMPLE_W-1:0], FRAC_W'(0)};
  assign div_req.den   = sum_d;

  wde_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Apply the sign and saturate; a zero time sum gives zero.
  always_comb begin
    if (sum_q == '0) begin
      d_sat = '0;
    end else if (neg_q) begin
      if (div_rsp.quot > {1'b1, (VALUE_W-1)'(0)}) begin
        d_sat = {1'b1, (VALUE_W-1)'(0)};
      end else begin
        d_sat = -$signed(div_rsp.quot);
      end
    end else if (div_rsp.quot[VALUE_W-1]) begin
      d_sat = {1'b0, {(VALUE_W-1){1'b1}}};
    end else begin
      d_sat = $signed(div_rsp.quot);
    end
  end

  // Divide the filter accumulator by 65536, truncating toward zero.
  assign acc_adj  = acc_q + (acc_q[PROD_W-1] ? PROD_W'((1 << FRAC_W) - 1) : PROD_W'(0));
  assign filt_new = acc_adj[FRAC_W +: VALUE_W];

  assign in_if.ready = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_if.req_type == REQ_CLEAR || len == SLOT_W'(1)) begin
            state_d = S_OUT;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: state_d = S_DIV;
      S_DIV: begin
        if (div_rsp.done) begin
          state_d = S_SAT;
        end
      end
      S_SAT:  state_d = ready_q ? S_MUL1 : S_OUT;
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_FIN;
      S_FIN:  state_d = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign cfg_clear = cfg_we_i && (cfg_idx_i == CFG_WINDOW);

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      win_q       <= WIN_RESET;
      gain_q      <= GAIN_RESET;
      slot_q      <= '0;
      sum_q       <= '0;
      filt_q      <= '0;
      ready_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WINDOW: win_q  <= cfg_wdata_i[WIN_W-1:0];
          CFG_GAIN:   gain_q <= cfg_wdata_i[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (cfg_clear || (accept && in_if.req_type == REQ_CLEAR)) begin
        slot_q  <= '0;
        sum_q   <= '0;
        filt_q  <= '0;
        ready_q <= 1'b0;
      end else begin
        if (mem_we) begin
          slot_q <= rd_slot;
        end
        if (state_q == S_READ) begin
          sum_q <= sum_d;
        end
        if (state_q == S_SAT && !ready_q && rd_is0_q) begin
          ready_q <= 1'b1;
          filt_q  <= d_sat;
        end
        if (state_q == S_FIN) begin
          filt_q <= filt_new;
        end
      end
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_q      <= in_if.sample;
      dt_q     <= in_if.time_step;
      rd_is0_q <= (rd_slot == '0);
      res_q    <= (in_if.req_type == REQ_SAMPLE && len == SLOT_W'(1)) ?
                  VALUE_W'(in_if.sample) : '0;
      live_q   <= (in_if.req_type == REQ_SAMPLE && len == SLOT_W'(1));
    end
    if (state_q == S_READ) begin
      neg_q <= diff[DIFF_W-1];
    end
    if (state_q == S_SAT) begin
      d_q    <= d_sat;
      res_q  <= '0;
      live_q <= 1'b0;
    end
    if (state_q == S_MUL1) begin
      p1_q <= d_q * $signed({1'b0, g_eff});
    end
    if (state_q == S_MUL2) begin
      acc_q <= p1_q + filt_q * $signed({1'b0, GAIN_ONE - g_eff});
    end
    if (state_q == S_FIN) begin
      res_q  <= filt_new;
      live_q <= 1'b1;
    end
    if (state_q == S_OUT && out_free) begin
      out_value_q <= res_q;
      out_live_q  <= live_q;
    end
  end

  assign out_if.valid    = out_valid_q;
  assign out_if.value    = out_value_q;
  assign out_if.is_ready = out_live_q;

  // The divider only ever reports completion while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == S_DIV)
    else $error("divider finished outside the divide state");

  // The ready flag is set only when the ring wraps during a sample request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ready_q) |-> $past(state_q) == S_SAT && $past(rd_is0_q))
    else $error("ready flag set without a ring wrap");

  // A clear request goes straight to the result stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_if.req_type == REQ_CLEAR |=> state_q == S_OUT && !ready_q)
    else $error("clear request did not clear and complete");

  // Leaving the result stage always presents a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT && out_free |=> out_valid_q && state_q == S_IDLE)
    else $error("result stage left without loading the output register");

endmodule

`default_nettype wire
